// ===== src/rrs_pkg.sv =====
// Shared types and constants for the round-robin scheduler.
`default_nettype none
package rrs_pkg;

  localparam int unsigned ID_W    = 6;
  localparam int unsigned BURST_W = 12;
  localparam int unsigned SLICE_W = 8;
  localparam int unsigned STAT_W  = 16;
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 48;

  localparam logic OP_ARRIVE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } rrs_state_e;

  typedef struct packed {
    logic load;
    logic exec;
  } rrs_cmd_t;

  typedef struct packed {
    logic out_stall;
  } rrs_sts_t;

endpackage
`default_nettype wire

// ===== src/rrs_ctrl.sv =====
// Sequencing FSM: accept a transaction, then run one update step.
`default_nettype none
module rrs_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire rrs_pkg::rrs_sts_t sts_i,
  output rrs_pkg::rrs_cmd_t  cmd_o
);
  import rrs_pkg::*;

  rrs_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (!sts_i.out_stall) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_EXEC: begin
        cmd_o.exec = !sts_i.out_stall;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== src/rrs_datapath.sv =====
// Ready queue memory, running-job registers, time base and result register.
`default_nettype none
module rrs_datapath #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned TIME_BITS   = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire rrs_pkg::rrs_cmd_t           cmd_i,
  output rrs_pkg::rrs_sts_t                sts_o,
  input  wire logic                        cfg_we_i,
  input  wire logic [rrs_pkg::SLICE_W-1:0] cfg_wdata_i,
  input  wire logic                        in_op_i,
  input  wire logic [rrs_pkg::ID_W-1:0]    in_id_i,
  input  wire logic [rrs_pkg::BURST_W-1:0] in_burst_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic                             out_accepted_o,
  output logic                             out_cpu_busy_o,
  output logic [rrs_pkg::ID_W-1:0]         out_running_id_o,
  output logic                             out_done_res_o,
  output logic [rrs_pkg::ID_W-1:0]         out_done_id_o,
  output logic [rrs_pkg::STAT_W-1:0]       out_turnaround_o,
  output logic [rrs_pkg::STAT_W-1:0]       out_waiting_o
);
  import rrs_pkg::*;

  localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned EXT_W = (TIME_BITS > STAT_W) ? TIME_BITS : STAT_W;

  typedef struct packed {
    logic [ID_W-1:0]      id;
    logic [BURST_W-1:0]   remaining;
    logic [BURST_W-1:0]   burst;
    logic [TIME_BITS-1:0] arrival;
  } job_t;

  job_t mem [QUEUE_DEPTH];
  job_t rd_q;

  logic [SLICE_W-1:0]   slice_cfg_q;
  logic [TIME_BITS-1:0] now_q, now_d;
  logic [IDX_W-1:0]     head_q, head_d, tail_q, tail_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 run_v_q, run_v_d;
  job_t                 run_q, run_d;
  logic [SLICE_W-1:0]   slice_q, slice_d;

  logic                 op_q;
  logic [ID_W-1:0]      id_q;
  logic [BURST_W-1:0]   burst_q;

  logic                 out_valid_q;
  logic                 acc_q, busy_q, done_q;
  logic [ID_W-1:0]      run_id_q, done_id_q;
  logic [STAT_W-1:0]    turn_q, wait_q;
  logic                 acc_d, busy_d, done_d;
  logic [ID_W-1:0]      run_id_d, done_id_d;
  logic [STAT_W-1:0]    turn_d, wait_d;

  logic                 wr_en;
  job_t                 wr_data;

  logic                 q_nonempty, q_full, expire, swap, dispatch, pop, cur_v;
  logic [SLICE_W-1:0]   quantum, slice0;
  job_t                 cur;
  logic [BURST_W-1:0]   burst_fix, rem_dec;
  logic [TIME_BITS-1:0] finish, turn;
  logic [EXT_W-1:0]     turn_ext, burst_ext, wait_ext;

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  assign sts_o.out_stall = out_valid_q && !out_ready_i;

  always_comb begin
    q_nonempty = (cnt_q != '0);
    q_full     = (cnt_q == CNT_W'(QUEUE_DEPTH));
    quantum    = (slice_cfg_q == '0) ? SLICE_W'(1) : slice_cfg_q;
    burst_fix  = (burst_q == '0) ? BURST_W'(1) : burst_q;

    expire   = run_v_q && (slice_q == '0);
    swap     = expire && q_nonempty;
    dispatch = !run_v_q && q_nonempty;
    pop      = swap || dispatch;
    cur      = pop ? rd_q : run_q;
    cur_v    = run_v_q || dispatch;
    slice0   = (expire || dispatch) ? quantum : slice_q;
    rem_dec  = (cur.remaining != '0) ? cur.remaining - 1'b1 : cur.remaining;

    finish    = now_q + 1'b1;
    turn      = finish - cur.arrival;
    turn_ext  = EXT_W'(turn);
    burst_ext = EXT_W'(cur.burst);
    wait_ext  = (turn_ext > burst_ext) ? turn_ext - burst_ext : '0;

    now_d   = now_q;
    head_d  = head_q;
    tail_d  = tail_q;
    cnt_d   = cnt_q;
    run_v_d = run_v_q;
    run_d   = run_q;
    slice_d = slice_q;
    wr_en   = 1'b0;
    wr_data = run_q;

    acc_d     = 1'b1;
    busy_d    = 1'b0;
    run_id_d  = '0;
    done_d    = 1'b0;
    done_id_d = '0;
    turn_d    = '0;
    wait_d    = '0;

    if (op_q == OP_ARRIVE) begin
      if (!q_full) begin
        wr_en             = 1'b1;
        wr_data.id        = id_q;
        wr_data.remaining = burst_fix;
        wr_data.burst     = burst_fix;
        wr_data.arrival   = now_q;
        tail_d            = next_idx(tail_q);
        cnt_d             = cnt_q + 1'b1;
      end else begin
        acc_d = 1'b0;
      end
    end else begin
      now_d = finish;
      if (pop) head_d = next_idx(head_q);
      if (swap) begin
        wr_en   = 1'b1;
        wr_data = run_q;
        tail_d  = next_idx(tail_q);
      end
      if (dispatch) cnt_d = cnt_q - 1'b1;
      run_v_d = cur_v;
      run_d   = cur;
      slice_d = slice0;
      if (cur_v) begin
        busy_d          = 1'b1;
        run_id_d        = cur.id;
        run_d.remaining = rem_dec;
        slice_d         = (slice0 != '0) ? slice0 - 1'b1 : '0;
        if (rem_dec == '0) begin
          done_d    = 1'b1;
          done_id_d = cur.id;
          turn_d    = (turn_ext > EXT_W'({STAT_W{1'b1}})) ? {STAT_W{1'b1}}
                                                          : turn_ext[STAT_W-1:0];
          wait_d    = (wait_ext > EXT_W'({STAT_W{1'b1}})) ? {STAT_W{1'b1}}
                                                          : wait_ext[STAT_W-1:0];
          run_v_d   = 1'b0;
          slice_d   = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && wr_en) mem[tail_q] <= wr_data;
    rd_q <= mem[head_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= in_op_i;
      id_q    <= in_id_i;
      burst_q <= in_burst_i;
    end
    if (cmd_i.exec) begin
      run_q     <= run_d;
      acc_q     <= acc_d;
      busy_q    <= busy_d;
      run_id_q  <= run_id_d;
      done_q    <= done_d;
      done_id_q <= done_id_d;
      turn_q    <= turn_d;
      wait_q    <= wait_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slice_cfg_q <= SLICE_W'(1);
      now_q       <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      cnt_q       <= '0;
      run_v_q     <= 1'b0;
      slice_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) slice_cfg_q <= cfg_wdata_i;
      if (cmd_i.exec) begin
        now_q   <= now_d;
        head_q  <= head_d;
        tail_q  <= tail_d;
        cnt_q   <= cnt_d;
        run_v_q <= run_v_d;
        slice_q <= slice_d;
      end
      if (cmd_i.exec) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_accepted_o   = acc_q;
  assign out_cpu_busy_o   = busy_q;
  assign out_running_id_o = run_id_q;
  assign out_done_res_o   = done_q;
  assign out_done_id_o    = done_id_q;
  assign out_turnaround_o = turn_q;
  assign out_waiting_o    = wait_q;

endmodule
`default_nettype wire

// ===== src/round_robin_scheduler_unit.sv =====
// Round-robin scheduler top level: stream ports, FSM and datapath.
// Each input transaction is registered in IDLE; the EXEC state then runs the update step on the
// registered queue-head read and sets the result valid. No new transaction is accepted until the
// update step and its requeue write are done, and a stalled result holds the update step.
// Reset: asynchronous, active low; empties the queue, stops the CPU, time to 0, quantum to 1.
// Queue memory contents are not cleared; entries are only read once written.
`default_nettype none
module round_robin_scheduler_unit #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned TIME_BITS   = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [rrs_pkg::SLICE_W-1:0]    cfg_wdata_i,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // [5:0] job_id, [17:6] burst_len, [23:18] zero
  input  wire logic [rrs_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // [0] op
  input  wire logic                           s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // [0] accepted, [1] cpu_busy, [7:2] running_id, [8] done_res, [14:9] done_id,
  // [30:15] done_turnaround, [46:31] done_waiting, [47] zero
  output logic [rrs_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);
  import rrs_pkg::*;

  rrs_cmd_t cmd;
  rrs_sts_t sts;

  logic              acc, busy, done;
  logic [ID_W-1:0]   run_id, done_id;
  logic [STAT_W-1:0] turn, waiting;

  rrs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rrs_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TIME_BITS   (TIME_BITS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_op_i          (s_axis_tuser),
    .in_id_i          (s_axis_tdata[5:0]),
    .in_burst_i       (s_axis_tdata[17:6]),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .out_accepted_o   (acc),
    .out_cpu_busy_o   (busy),
    .out_running_id_o (run_id),
    .out_done_res_o   (done),
    .out_done_id_o    (done_id),
    .out_turnaround_o (turn),
    .out_waiting_o    (waiting)
  );

  assign m_axis_tdata = {1'b0, waiting, turn, done_id, done, run_id, busy, acc};

endmodule
`default_nettype wire

// ===== verif/rrs_checker.sv =====
// Scoreboard for the round-robin scheduler: tracks queue and CPU state, checks every report.
`default_nettype none
module rrs_checker #(
  parameter int unsigned QDEPTH = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [rrs_pkg::SLICE_W-1:0]     cfg_wdata_i,
  input  wire logic                            in_valid_i,
  input  wire logic                            in_ready_i,
  input  wire logic [rrs_pkg::IN_DATA_W-1:0]   in_data_i,
  input  wire logic                            in_user_i,
  input  wire logic                            out_valid_i,
  input  wire logic                            out_ready_i,
  input  wire logic [rrs_pkg::OUT_DATA_W-1:0]  out_data_i,
  output int unsigned                          fail_cnt_o,
  output int unsigned                          backlog_o,
  output int unsigned                          drop_cnt_o,
  output int unsigned                          done_cnt_o
);
  import rrs_pkg::*;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [BURST_W-1:0] remaining;
    logic [BURST_W-1:0] burst;
    logic [STAT_W-1:0]  arrival;
  } job_t;

  typedef struct packed {
    logic              accepted;
    logic              cpu_busy;
    logic [ID_W-1:0]   running_id;
    logic              done_res;
    logic [ID_W-1:0]   done_id;
    logic [STAT_W-1:0] turnaround;
    logic [STAT_W-1:0] waiting;
  } sched_report_t;

  // scheduler shadow state
  logic [SLICE_W-1:0] slice_cfg;
  logic [STAT_W-1:0]  now_t;
  job_t               ready_q [QDEPTH];
  int unsigned        q_head, q_tail, q_count;
  logic               run_valid;
  job_t               run_job;
  int unsigned        slice_left;

  sched_report_t      pending_reports[$];
  sched_report_t      want, got;

  initial begin
    fail_cnt_o = 0;
    backlog_o  = 0;
    drop_cnt_o = 0;
    done_cnt_o = 0;
  end

  task automatic push_job(input job_t j);
    ready_q[q_tail] = j;
    q_tail  = (q_tail + 1) % QDEPTH;
    q_count = q_count + 1;
  endtask

  task automatic pop_job(output job_t j);
    j = ready_q[q_head];
    q_head  = (q_head + 1) % QDEPTH;
    q_count = q_count - 1;
  endtask

  task automatic advance_scheduler(input logic op, input logic [ID_W-1:0] id,
                                   input logic [BURST_W-1:0] burst,
                                   output sched_report_t r);
    job_t        j;
    job_t        prev;
    int unsigned quantum;
    logic [STAT_W-1:0] finish_t, turn;
    r = '0;
    r.accepted = 1'b1;
    quantum = (slice_cfg == '0) ? 1 : slice_cfg;
    if (op == OP_ARRIVE) begin
      if (q_count < QDEPTH) begin
        j.id        = id;
        j.burst     = (burst == '0) ? BURST_W'(1) : burst;
        j.remaining = j.burst;
        j.arrival   = now_t;
        push_job(j);
      end else begin
        r.accepted = 1'b0;
      end
    end else begin
      // quantum used up: rotate with the head, or keep running when alone
      if (run_valid && slice_left == 0) begin
        if (q_count > 0) begin
          prev = run_job;
          pop_job(run_job);
          push_job(prev);
        end
        slice_left = quantum;
      end
      if (!run_valid && q_count > 0) begin
        pop_job(run_job);
        run_valid  = 1'b1;
        slice_left = quantum;
      end
      if (run_valid) begin
        r.cpu_busy   = 1'b1;
        r.running_id = run_job.id;
        if (run_job.remaining != '0) run_job.remaining = run_job.remaining - 1'b1;
        if (slice_left > 0) slice_left = slice_left - 1;
        if (run_job.remaining == '0) begin
          finish_t     = now_t + 1'b1;
          turn         = finish_t - run_job.arrival;
          r.done_res   = 1'b1;
          r.done_id    = run_job.id;
          r.turnaround = turn;
          r.waiting    = (turn > STAT_W'(run_job.burst)) ? turn - STAT_W'(run_job.burst) : '0;
          run_valid    = 1'b0;
          slice_left   = 0;
        end
      end
      now_t = now_t + 1'b1;
    end
  endtask

  task automatic check_field(input string name, input int unsigned exp_v, input int unsigned act_v);
    if (exp_v != act_v) begin
      fail_cnt_o = fail_cnt_o + 1;
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slice_cfg  = SLICE_W'(1);
      now_t      = '0;
      q_head     = 0;
      q_tail     = 0;
      q_count    = 0;
      run_valid  = 1'b0;
      run_job    = '0;
      slice_left = 0;
      pending_reports.delete();
      backlog_o  = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got.accepted   = out_data_i[0];
        got.cpu_busy   = out_data_i[1];
        got.running_id = out_data_i[7:2];
        got.done_res   = out_data_i[8];
        got.done_id    = out_data_i[14:9];
        got.turnaround = out_data_i[30:15];
        got.waiting    = out_data_i[46:31];
        if (pending_reports.size() == 0) begin
          fail_cnt_o = fail_cnt_o + 1;
          $error("report transaction with nothing outstanding: %h", out_data_i);
        end else begin
          want = pending_reports.pop_front();
          backlog_o = backlog_o - 1;
          check_field("accepted", want.accepted, got.accepted);
          check_field("cpu_busy", want.cpu_busy, got.cpu_busy);
          check_field("running_id", want.running_id, got.running_id);
          check_field("done_res", want.done_res, got.done_res);
          check_field("done_id", want.done_id, got.done_id);
          check_field("done_turnaround", want.turnaround, got.turnaround);
          check_field("done_waiting", want.waiting, got.waiting);
          check_field("pad bit", 0, out_data_i[47]);
        end
      end
      if (cfg_we_i) slice_cfg = cfg_wdata_i;
      if (in_valid_i && in_ready_i) begin
        advance_scheduler(in_user_i, in_data_i[5:0], in_data_i[17:6], want);
        pending_reports.insert(pending_reports.size(), want);
        backlog_o = backlog_o + 1;
        if (!want.accepted) drop_cnt_o = drop_cnt_o + 1;
        if (want.done_res) done_cnt_o = done_cnt_o + 1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
// Top-level testbench: clock, reset, stimulus for the round-robin scheduler and the verdict.
`default_nettype none
module testbench;
  import rrs_pkg::*;

  localparam int unsigned N_PHASES    = 6;
  localparam int unsigned PHASE_ITEMS = 263;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned QUIET_PHASE = 3;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [SLICE_W-1:0]    cfg_wdata_i   = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  s_axis_tuser  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  logic        quiet     = 1'b0;
  int unsigned cycle_cnt = 0;
  int unsigned sent_cnt  = 0;
  int unsigned fail_cnt, backlog, drop_cnt, done_cnt;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  round_robin_scheduler_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  rrs_checker #(.QDEPTH(16)) u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_i  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .out_valid_i (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_i  (m_axis_tdata),
    .fail_cnt_o  (fail_cnt),
    .backlog_o   (backlog),
    .drop_cnt_o  (drop_cnt),
    .done_cnt_o  (done_cnt)
  );

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("testbench: timeout after %0d cycles", cycle_cnt);
      $display("testbench: done, errors");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 7);
  end

  task automatic send_item(input logic op, input logic [ID_W-1:0] id,
                           input logic [BURST_W-1:0] burst);
    while (!quiet && $urandom_range(0, 99) < 7) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {6'b0, burst, id};
    do @(posedge clk_i); while (!s_axis_tready);
    sent_cnt++;
  endtask

  // quantum changes only once the block has drained
  task automatic set_slice(input logic [SLICE_W-1:0] v);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (backlog != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    int unsigned ph, k, arr_pct, pick;
    logic [BURST_W-1:0] b;
    logic [SLICE_W-1:0] sl;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: idle tick, zero burst, max burst, expiry when alone, full queue, requeue when full
    send_item(OP_TICK, '0, '0);
    send_item(OP_ARRIVE, 6'd63, 12'd0);
    send_item(OP_ARRIVE, 6'd0, 12'd4095);
    send_item(OP_TICK, 6'd63, 12'd4095);
    send_item(OP_TICK, '0, '0);
    send_item(OP_TICK, '0, '0);
    for (k = 0; k < 17; k++) send_item(OP_ARRIVE, ID_W'(k + 1), BURST_W'(k % 4 + 1));
    send_item(OP_TICK, '0, '0);

    for (ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0:       sl = 8'd0;
        1:       sl = 8'd255;
        2:       sl = 8'd1;
        3:       sl = 8'd2;
        4:       sl = SLICE_W'($urandom_range(3, 254));
        default: sl = 8'd3;
      endcase
      set_slice(sl);
      quiet   <= (ph == QUIET_PHASE);
      arr_pct = $urandom_range(20, 45);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 99) < arr_pct) begin
          pick = $urandom_range(0, 99);
          if (pick < 1)       b = BURST_W'($urandom_range(0, 4095));
          else if (pick < 12) b = BURST_W'($urandom_range(5, 40));
          else                b = BURST_W'($urandom_range(1, 4));
          send_item(OP_ARRIVE, ID_W'($urandom_range(0, 63)), b);
        end else begin
          // tick with junk in the ignored fields
          send_item(OP_TICK, ID_W'($urandom), BURST_W'($urandom));
        end
      end
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (backlog != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    $display("testbench: %0d transactions over %0d quantum settings, %0d jobs completed,",
             sent_cnt, N_PHASES + 1, done_cnt);
    $display("testbench: %0d arrivals turned away on a full queue, %0d mismatches",
             drop_cnt, fail_cnt);
    if (fail_cnt == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== round_robin_scheduler_unit.f =====
src/rrs_pkg.sv
src/rrs_ctrl.sv
src/rrs_datapath.sv
src/round_robin_scheduler_unit.sv
verif/rrs_checker.sv
verif/testbench.sv
